FILE: hw/rtl/efan_pkg.sv
// efan_pkg: shared types, constants and tables of the ellipse fan tessellator.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none
package efan_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int SEG_W            = 7;

   // sine polynomial coefficients, Q1.30
   localparam logic [30:0] K1 = 31'd1686629713;
   localparam logic [30:0] K3 = 31'd693598669;
   localparam logic [30:0] K5 = 31'd85569306;
   localparam logic [30:0] K7 = 31'd5026995;
   localparam logic [30:0] K9 = 31'd172272;
   localparam logic [31:0] ONE30 = 32'd1073741824;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        radius_x;
      logic [15:0]        radius_y;
      logic [15:0]        rotation;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic [SEG_W-1:0]   segs;
   } shape_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

   typedef enum logic [1:0] {SN_IDLE, SN_MUL, SN_ADD} sine_state_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_DIV, BK_ROTC, BK_ROTS, BK_RIMC, BK_RIMS,
      BK_LOCAL, BK_MUL, BK_FIN, BK_EMIT
   } back_state_type;

   // horner coefficient for each polynomial step
   function automatic logic [30:0] coef(input logic [2:0] step);
      logic [30:0] c;
      unique case (step)
         3'd1:    c = K7;
         3'd2:    c = K5;
         3'd3:    c = K3;
         default: c = K1;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ellipse_fan_tessellator.sv
// Ellipse fan tessellator top level: front, shape queue and back sequencer.
// Depends on efan_pkg, efan_front, efan_fifo, efan_back.
//
// Usage: each req_ transfer carries one ellipse (centre, radii, rotation, colour,
// segment count). The block returns one rsp_ transfer per fan triangle, in order,
// with rsp_last_triangle set on the final triangle of a shape. A count of zero
// is taken and produces nothing; counts above MAX_SEGMENTS are clamped.
// Shapes wait in a two-entry queue, so req_ready stays high while the back
// end works, until the queue is full.
// Sequence: a shape first passes the hand-off and the serial divider that finds its
// phase step, then the rotation sine and cosine (each six multiply/round steps on the
// shared sine unit, plus start and hand-off). Each rim point takes two sines, the
// local products, five steps on the shared rotation multiplier and a step to round
// and saturate; every rim point after the first adds an emit step and yields one
// triangle.
// Reset (synchronous, active high) empties the queue and drops any shape in work.
// When the receiver stalls, the finished triangle is held in the output register
// and the back end waits with the next one; the front keeps filling the queue.
`default_nettype none
module ellipse_fan_tessellator #(
   parameter int MAX_SEGMENTS = efan_pkg::MAX_SEGMENTS_DEF,
   parameter int ANGLE_BITS   = efan_pkg::ANGLE_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire signed [15:0]          req_center_x,
   input  wire signed [15:0]          req_center_y,
   input  wire [15:0]                 req_radius_x,
   input  wire [15:0]                 req_radius_y,
   input  wire [15:0]                 req_rotation,
   input  wire [7:0]                  req_red,
   input  wire [7:0]                  req_green,
   input  wire [7:0]                  req_blue,
   input  wire [7:0]                  req_alpha,
   input  wire [efan_pkg::SEG_W-1:0]  req_segment_count,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic signed [15:0]         rsp_hub_x,
   output logic signed [15:0]         rsp_hub_y,
   output logic signed [15:0]         rsp_rim0_x,
   output logic signed [15:0]         rsp_rim0_y,
   output logic signed [15:0]         rsp_rim1_x,
   output logic signed [15:0]         rsp_rim1_y,
   output logic [7:0]                 rsp_out_red,
   output logic [7:0]                 rsp_out_green,
   output logic [7:0]                 rsp_out_blue,
   output logic [7:0]                 rsp_out_alpha,
   output logic                       rsp_last_triangle
);
   import efan_pkg::*;

   queue_ctl_type  q_status, q_ctl;
   shape_type      in_shape, head_shape;
   logic           head_valid, pop;

   // front: accept and classify
   efan_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius_x      (req_radius_x),
      .req_radius_y      (req_radius_y),
      .req_rotation      (req_rotation),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_alpha         (req_alpha),
      .req_segment_count (req_segment_count),
      .queue_in          (q_status),
      .queue_out         (q_ctl),
      .shape             (in_shape)
   );

   assign q_status.push = 1'b0;

   // shape queue
   efan_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_ctl.push),
      .push_data (in_shape),
      .pop       (pop),
      .full      (q_status.full),
      .not_empty (head_valid),
      .head      (head_shape)
   );

   // back: triangle generation
   efan_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .shape_valid       (head_valid),
      .shape             (head_shape),
      .shape_pop         (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hub_x         (rsp_hub_x),
      .rsp_hub_y         (rsp_hub_y),
      .rsp_rim0_x        (rsp_rim0_x),
      .rsp_rim0_y        (rsp_rim0_y),
      .rsp_rim1_x        (rsp_rim1_x),
      .rsp_rim1_y        (rsp_rim1_y),
      .rsp_out_red       (rsp_out_red),
      .rsp_out_green     (rsp_out_green),
      .rsp_out_blue      (rsp_out_blue),
      .rsp_out_alpha     (rsp_out_alpha),
      .rsp_last_triangle (rsp_last_triangle)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/efan_fifo.sv
// efan_fifo: short shape queue between front and back.
// Depends on efan_pkg.
`default_nettype none
module efan_fifo (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  efan_pkg::shape_type    push_data,
   input  wire                    pop,
   output logic                   full,
   output logic                   not_empty,
   output efan_pkg::shape_type    head
);
   import efan_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   shape_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]      cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/efan_front.sv
// efan_front: accepts shapes, clamps the segment count, drops empty shapes.
// Depends on efan_pkg.
`default_nettype none
module efan_front #(
   parameter int MAX_SEGMENTS = efan_pkg::MAX_SEGMENTS_DEF
) (
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire signed [15:0]           req_center_x,
   input  wire signed [15:0]           req_center_y,
   input  wire [15:0]                  req_radius_x,
   input  wire [15:0]                  req_radius_y,
   input  wire [15:0]                  req_rotation,
   input  wire [7:0]                   req_red,
   input  wire [7:0]                   req_green,
   input  wire [7:0]                   req_blue,
   input  wire [7:0]                   req_alpha,
   input  wire [efan_pkg::SEG_W-1:0]   req_segment_count,
   input  efan_pkg::queue_ctl_type     queue_in,
   output efan_pkg::queue_ctl_type     queue_out,
   output efan_pkg::shape_type         shape
);
   import efan_pkg::*;

   logic [SEG_W-1:0] segs;

   // clamp count to the segment limit
   assign segs = (req_segment_count > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS)
                                                            : req_segment_count;
   assign req_ready = !queue_in.full;

   always_comb begin
      shape.center_x = req_center_x;
      shape.center_y = req_center_y;
      shape.radius_x = req_radius_x;
      shape.radius_y = req_radius_y;
      shape.rotation = req_rotation;
      shape.red      = req_red;
      shape.green    = req_green;
      shape.blue     = req_blue;
      shape.alpha    = req_alpha;
      shape.segs     = segs;
   end

   // empty shapes are taken but never queued
   assign queue_out.push = req_valid && req_ready && (segs != '0);
   assign queue_out.full = queue_in.full;
endmodule
`default_nettype wire

FILE: hw/rtl/efan_sine.sv
// efan_sine: multicycle Q1.15 sine of a turn-fraction phase, one shared multiplier.
// Depends on efan_pkg.
`default_nettype none
module efan_sine #(
   parameter int ANGLE_BITS = efan_pkg::ANGLE_BITS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire [ANGLE_BITS-1:0]   phase,
   output logic                   done,
   output logic signed [16:0]     value
);
   import efan_pkg::*;

   localparam int USH = 32 - ANGLE_BITS;

   sine_state_type      state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic [1:0]          quad_ff, quad_in;
   logic [30:0]         u_ff, u_in, u2_ff, u2_in, a_ff, a_in, b_ff, b_in;
   logic [61:0]         prod_ff, prod_in;
   logic                done_ff, done_in;
   logic signed [16:0]  value_ff, value_in;

   logic [30:0]         u_raw;
   logic [61:0]         rsum;
   logic [31:0]         r;
   logic [30:0]         pnew;
   logic [31:0]         pc;
   logic [31:0]         s32;
   logic [16:0]         s;

   assign done  = done_ff;
   assign value = value_ff;

   // quarter-wave argument and rounded product
   assign u_raw = 31'(phase[ANGLE_BITS-3:0]) << USH;
   assign rsum  = prod_ff + 62'd536870912;
   assign r     = rsum[61:30];
   assign pnew  = coef(step_ff) - r[30:0];
   assign pc    = (r > ONE30) ? ONE30 : r;
   assign s32   = (pc + 32'd16384) >> 15;
   assign s     = (s32 > 32'd32768) ? 17'd32768 : s32[16:0];

   // horner sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quad_in  = quad_ff;
      u_in     = u_ff;
      u2_in    = u2_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      unique case (state_ff)
         SN_IDLE: begin
            if (start) begin
               quad_in  = phase[ANGLE_BITS-1:ANGLE_BITS-2];
               u_in     = phase[ANGLE_BITS-2] ? (ONE30[30:0] - u_raw) : u_raw;
               a_in     = u_in;
               b_in     = u_in;
               step_in  = 3'd0;
               state_in = SN_MUL;
            end
         end
         SN_MUL: begin
            prod_in  = a_ff * b_ff;
            state_in = SN_ADD;
         end
         SN_ADD: begin
            state_in = SN_MUL;
            step_in  = step_ff + 1'b1;
            priority if (step_ff == 3'd0) begin
               u2_in = r[30:0];
               a_in  = K9;
               b_in  = r[30:0];
            end else if (step_ff == 3'd5) begin
               value_in = quad_ff[1] ? -$signed(s) : $signed(s);
               done_in  = 1'b1;
               state_in = SN_IDLE;
            end else begin
               a_in = pnew;
               b_in = (step_ff == 3'd4) ? u_ff : u2_ff;
            end
         end
         default: state_in = SN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SN_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      quad_ff  <= quad_in;
      u_ff     <= u_in;
      u2_ff    <= u2_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end
endmodule
`default_nettype wire

FILE: hw/rtl/efan_back.sv
// efan_back: per-shape sequencer: phase step division, rim points, triangle output.
// Depends on efan_pkg and efan_sine.
`default_nettype none
module efan_back #(
   parameter int ANGLE_BITS = efan_pkg::ANGLE_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   shape_valid,
   input  efan_pkg::shape_type   shape,
   output logic                  shape_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic signed [15:0]    rsp_hub_x,
   output logic signed [15:0]    rsp_hub_y,
   output logic signed [15:0]    rsp_rim0_x,
   output logic signed [15:0]    rsp_rim0_y,
   output logic signed [15:0]    rsp_rim1_x,
   output logic signed [15:0]    rsp_rim1_y,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic [7:0]            rsp_out_alpha,
   output logic                  rsp_last_triangle
);
   import efan_pkg::*;

   localparam int AB = ANGLE_BITS;
   localparam int CNTW = $clog2(AB + 1);
   localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

   back_state_type      state_ff, state_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [SEG_W-1:0]    rem_ff, rem_in, rf_ff, rf_in, r_ff, r_in, k_ff, k_in;
   logic [AB-1:0]       quo_ff, quo_in, qf_ff, qf_in, q_ff, q_in;
   logic                pend_ff, pend_in;
   logic signed [16:0]  cr_ff, cr_in, sr_ff, sr_in, cs_ff, cs_in, sn_ff, sn_in;
   logic signed [33:0]  lx_ff, lx_in, ly_ff, ly_in;
   logic signed [50:0]  prod_ff, prod_in, xacc_ff, xacc_in, yacc_ff, yacc_in;
   logic signed [15:0]  prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic signed [15:0]  curx_ff, curx_in, cury_ff, cury_in;
   logic                ov_ff, ov_in;
   logic signed [15:0]  o_r0x_ff, o_r0x_in, o_r0y_ff, o_r0y_in;
   logic signed [15:0]  o_r1x_ff, o_r1x_in, o_r1y_ff, o_r1y_in;
   logic signed [15:0]  o_hx_ff, o_hx_in, o_hy_ff, o_hy_in;
   logic [7:0]          o_r_ff, o_r_in, o_g_ff, o_g_in, o_b_ff, o_b_in, o_a_ff, o_a_in;
   logic                o_last_ff, o_last_in;

   logic                sin_start, sin_done;
   logic [AB-1:0]       sin_phase, rot_phase;
   logic signed [16:0]  sin_value;
   logic [23:0]         rot_wide;
   logic [7:0]          rem_sh;
   logic                ge;
   logic [SEG_W:0]      rsum;
   logic signed [33:0]  mul_a;
   logic signed [16:0]  mul_b;
   logic signed [50:0]  mul_p;
   logic signed [15:0]  satx, saty;

   efan_sine #(.ANGLE_BITS(AB)) u_sine (
      .clock (clock),
      .reset (reset),
      .start (sin_start),
      .phase (sin_phase),
      .done  (sin_done),
      .value (sin_value)
   );

   // rotation widened or narrowed to the phase width
   assign rot_wide  = {shape.rotation, 8'h00};
   assign rot_phase = rot_wide[23 -: AB];

   // divider step for 2^AB / segs
   assign rem_sh = {rem_ff, (cnt_ff == CNTW'(AB))};
   assign ge     = (rem_sh >= {1'b0, shape.segs});
   assign rsum   = {1'b0, r_ff} + {1'b0, rf_ff};

   // shared rotation multiplier
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    begin mul_a = lx_ff; mul_b = cr_ff; end
         2'd1:    begin mul_a = ly_ff; mul_b = sr_ff; end
         2'd2:    begin mul_a = lx_ff; mul_b = sr_ff; end
         default: begin mul_a = ly_ff; mul_b = cr_ff; end
      endcase
      mul_p = mul_a * mul_b;
   end

   // round half up, offset by centre and saturate
   function automatic logic signed [15:0] finish(input logic signed [50:0] acc,
                                                 input logic signed [15:0] c);
      logic signed [50:0] t;
      logic signed [21:0] v;
      t = acc + 51'sd536870912;
      v = 22'(t >>> 30) + 22'(c);
      if (v > 22'sd32767) begin
         return 16'sh7fff;
      end else if (v < -22'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   assign satx = finish(xacc_ff, shape.center_x);
   assign saty = finish(yacc_ff, shape.center_y);

   // shape sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      qf_in     = qf_ff;
      rf_in     = rf_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      pend_in   = pend_ff;
      cr_in     = cr_ff;
      sr_in     = sr_ff;
      cs_in     = cs_ff;
      sn_in     = sn_ff;
      lx_in     = lx_ff;
      ly_in     = ly_ff;
      prod_in   = prod_ff;
      xacc_in   = xacc_ff;
      yacc_in   = yacc_ff;
      prevx_in  = prevx_ff;
      prevy_in  = prevy_ff;
      curx_in   = curx_ff;
      cury_in   = cury_ff;
      o_r0x_in  = o_r0x_ff;
      o_r0y_in  = o_r0y_ff;
      o_r1x_in  = o_r1x_ff;
      o_r1y_in  = o_r1y_ff;
      o_hx_in   = o_hx_ff;
      o_hy_in   = o_hy_ff;
      o_r_in    = o_r_ff;
      o_g_in    = o_g_ff;
      o_b_in    = o_b_ff;
      o_a_in    = o_a_ff;
      o_last_in = o_last_ff;
      ov_in     = ov_ff && !rsp_ready;
      shape_pop = 1'b0;
      sin_start = 1'b0;
      sin_phase = q_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (shape_valid) begin
               cnt_in   = CNTW'(AB);
               rem_in   = '0;
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            rem_in = ge ? SEG_W'(rem_sh - {1'b0, shape.segs}) : rem_sh[SEG_W-1:0];
            quo_in = {quo_ff[AB-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               qf_in    = {quo_ff[AB-2:0], ge};
               rf_in    = rem_in;
               q_in     = '0;
               r_in     = shape.segs >> 1;
               k_in     = '0;
               state_in = BK_ROTC;
            end
         end
         BK_ROTC, BK_ROTS, BK_RIMC, BK_RIMS: begin
            unique case (state_ff)
               BK_ROTC: sin_phase = rot_phase + QUARTER;
               BK_ROTS: sin_phase = rot_phase;
               BK_RIMC: sin_phase = q_ff + QUARTER;
               default: sin_phase = q_ff;
            endcase
            sin_start = !pend_ff;
            pend_in   = 1'b1;
            if (sin_done) begin
               pend_in = 1'b0;
               unique case (state_ff)
                  BK_ROTC: begin cr_in = sin_value; state_in = BK_ROTS; end
                  BK_ROTS: begin sr_in = sin_value; state_in = BK_RIMC; end
                  BK_RIMC: begin cs_in = sin_value; state_in = BK_RIMS; end
                  default: begin sn_in = sin_value; state_in = BK_LOCAL; end
               endcase
            end
         end
         BK_LOCAL: begin
            lx_in    = cs_ff * $signed({1'b0, shape.radius_x});
            ly_in    = sn_ff * $signed({1'b0, shape.radius_y});
            cnt_in   = '0;
            state_in = BK_MUL;
         end
         BK_MUL: begin
            prod_in = mul_p;
            cnt_in  = cnt_ff + 1'b1;
            unique case (cnt_ff[2:0])
               3'd0:    ;
               3'd1:    xacc_in = prod_ff;
               3'd2:    xacc_in = xacc_ff - prod_ff;
               3'd3:    yacc_in = prod_ff;
               default: begin
                  yacc_in  = yacc_ff + prod_ff;
                  state_in = BK_FIN;
               end
            endcase
         end
         BK_FIN: begin
            if (k_ff == '0) begin
               prevx_in = satx;
               prevy_in = saty;
               state_in = BK_RIMC;
            end else begin
               curx_in  = satx;
               cury_in  = saty;
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in     = 1'b1;
               o_hx_in   = shape.center_x;
               o_hy_in   = shape.center_y;
               o_r0x_in  = prevx_ff;
               o_r0y_in  = prevy_ff;
               o_r1x_in  = curx_ff;
               o_r1y_in  = cury_ff;
               o_r_in    = shape.red;
               o_g_in    = shape.green;
               o_b_in    = shape.blue;
               o_a_in    = shape.alpha;
               o_last_in = (k_ff == shape.segs);
               prevx_in  = curx_ff;
               prevy_in  = cury_ff;
               if (k_ff == shape.segs) begin
                  shape_pop = 1'b1;
                  state_in  = BK_IDLE;
               end else begin
                  state_in = BK_RIMC;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      // step to the next rim phase
      if ((state_ff == BK_FIN && k_ff == '0) ||
          (state_ff == BK_EMIT && state_in == BK_RIMC)) begin
         k_in = k_ff + 1'b1;
         if (rsum >= {1'b0, shape.segs}) begin
            r_in = SEG_W'(rsum - {1'b0, shape.segs});
            q_in = q_ff + qf_ff + 1'b1;
         end else begin
            r_in = rsum[SEG_W-1:0];
            q_in = q_ff + qf_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      qf_ff     <= qf_in;
      rf_ff     <= rf_in;
      q_ff      <= q_in;
      r_ff      <= r_in;
      k_ff      <= k_in;
      cr_ff     <= cr_in;
      sr_ff     <= sr_in;
      cs_ff     <= cs_in;
      sn_ff     <= sn_in;
      lx_ff     <= lx_in;
      ly_ff     <= ly_in;
      prod_ff   <= prod_in;
      xacc_ff   <= xacc_in;
      yacc_ff   <= yacc_in;
      prevx_ff  <= prevx_in;
      prevy_ff  <= prevy_in;
      curx_ff   <= curx_in;
      cury_ff   <= cury_in;
      o_r0x_ff  <= o_r0x_in;
      o_r0y_ff  <= o_r0y_in;
      o_r1x_ff  <= o_r1x_in;
      o_r1y_ff  <= o_r1y_in;
      o_hx_ff   <= o_hx_in;
      o_hy_ff   <= o_hy_in;
      o_r_ff    <= o_r_in;
      o_g_ff    <= o_g_in;
      o_b_ff    <= o_b_in;
      o_a_ff    <= o_a_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_hub_x         = o_hx_ff;
   assign rsp_hub_y         = o_hy_ff;
   assign rsp_rim0_x        = o_r0x_ff;
   assign rsp_rim0_y        = o_r0y_ff;
   assign rsp_rim1_x        = o_r1x_ff;
   assign rsp_rim1_y        = o_r1y_ff;
   assign rsp_out_red       = o_r_ff;
   assign rsp_out_green     = o_g_ff;
   assign rsp_out_blue      = o_b_ff;
   assign rsp_out_alpha     = o_a_ff;
   assign rsp_last_triangle = o_last_ff;
endmodule
`default_nettype wire
